// ===== hdl/yuyv_to_rgb565_converter_macros.svh =====
// Assertion macros for the YUYV to RGB565 converter.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef YUYV_TO_RGB565_CONVERTER_MACROS_SVH
`define YUYV_TO_RGB565_CONVERTER_MACROS_SVH

// same-cycle implication, checked out of reset
`define Y2R_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define Y2R_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/y2r_pkg.sv =====
// Shared types, constants and functions of the YUYV to RGB565 converter.
// No dependencies.
package y2r_pkg;

  // color coefficients in units of 1/256
  localparam logic signed [8:0] CoefRV = 9'sd103;
  localparam logic signed [8:0] CoefGU = 9'sd88;
  localparam logic signed [8:0] CoefGV = 9'sd183;
  localparam logic signed [8:0] CoefBU = 9'sd198;

  // offset-binary chroma: flipping the MSB is the same as subtracting 128
  localparam logic [7:0] ChromaBias = 8'h80;

  localparam logic signed [9:0] ChanMax = 10'sd255;

  // chroma contributions to each channel, shared by both pixels of a pair
  typedef struct packed {
    logic signed [8:0] r_off;
    logic signed [8:0] g_off;
    logic signed [8:0] b_off;
  } chroma_t;

  function automatic logic [7:0] clamp_u8(input logic signed [9:0] x);
    logic [7:0] res;
    if (x > ChanMax) begin
      res = 8'hff;
    end else if (x[9]) begin
      res = 8'h00;
    end else begin
      res = x[7:0];
    end
    return res;
  endfunction

  // RGB565 with bytes swapped: R5 G3(high) in the low byte
  function automatic logic [15:0] pack565_swapped(input logic [7:0] r,
                                                   input logic [7:0] g,
                                                   input logic [7:0] b);
    logic [15:0] w;
    w = {r[7:3], g[7:2], b[7:3]};
    return {w[7:0], w[15:8]};
  endfunction

endpackage

// ===== hdl/y2r_in_if.sv =====
// Input channel of the converter: one YUYV macropixel per beat.
// No dependencies.
interface y2r_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma_first;
  logic [7:0] chroma_blue;
  logic [7:0] luma_second;
  logic [7:0] chroma_red;
  logic       frame_end;

  modport source (output valid, luma_first, chroma_blue, luma_second, chroma_red,
                  frame_end, input ready);
  modport sink   (input valid, luma_first, chroma_blue, luma_second, chroma_red,
                  frame_end, output ready);
endinterface

// ===== hdl/y2r_out_if.sv =====
// Output channel of the converter: two byte-swapped RGB565 pixels per beat.
// No dependencies.
interface y2r_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_first;
  logic [15:0] pixel_second;
  logic        frame_end_out;

  modport source (output valid, pixel_first, pixel_second, frame_end_out,
                  input ready);
  modport sink   (input valid, pixel_first, pixel_second, frame_end_out,
                  output ready);
endinterface

// ===== hdl/yuyv_to_rgb565_converter.sv =====
// Channel  Dir  Beat content                                   Handshake
// in_i     in   luma_first, chroma_blue, luma_second,          valid/ready
//               chroma_red, frame_end
// out_o    out  pixel_first, pixel_second, frame_end_out       valid/ready
//
// One beat in and one beat out per clock when out_o is not stalled.
// A beat passes through the chroma stage register, then the output register.
// Both stages hold while out_o stalls; in_i stays ready while stage one is empty.
// Reset clears the two valid flags only; payload registers are not reset.
//
// Top level of the YUYV to RGB565 converter. Depends on y2r_pkg, y2r_in_if,
// y2r_out_if, y2r_chroma, y2r_lane and the assertion macro header.
`include "yuyv_to_rgb565_converter_macros.svh"

module yuyv_to_rgb565_converter (
  input  logic       clk_i,
  input  logic       rst_ni,
  y2r_in_if.sink     in_i,
  y2r_out_if.source  out_o
);
  import y2r_pkg::*;

  // stage one: shared chroma offsets plus both luma samples
  chroma_t    terms_d, terms_q;
  logic [7:0] luma0_q, luma1_q;
  logic       fe_q;
  logic       s1_valid_d, s1_valid_q;

  // output stage: lanes merged into one beat
  logic [15:0] pix0_d, pix0_q, pix1_d, pix1_q;
  logic        fe_out_q;
  logic        out_valid_d, out_valid_q;

  logic advance;   // output register may take stage one this cycle
  logic s1_load;   // stage one takes a new beat

  assign advance     = !out_valid_q || out_o.ready;
  assign in_i.ready  = !s1_valid_q || advance;
  assign s1_load     = in_i.valid && in_i.ready;

  assign s1_valid_d  = in_i.ready ? in_i.valid : s1_valid_q;
  assign out_valid_d = advance ? s1_valid_q : out_valid_q;

  // chroma is computed once per pair and shared by both lanes
  y2r_chroma u_chroma (
    .chroma_blue_i (in_i.chroma_blue),
    .chroma_red_i  (in_i.chroma_red),
    .terms_o       (terms_d)
  );

  y2r_lane u_lane0 (
    .luma_i  (luma0_q),
    .terms_i (terms_q),
    .pixel_o (pix0_d)
  );

  y2r_lane u_lane1 (
    .luma_i  (luma1_q),
    .terms_i (terms_q),
    .pixel_o (pix1_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // capture a new pair only on an accepted beat
  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      terms_q <= terms_d;
      luma0_q <= in_i.luma_first;
      luma1_q <= in_i.luma_second;
      fe_q    <= in_i.frame_end;
    end
  end

  // merge both lanes and the frame mark into the output beat; hold on stall
  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      pix0_q   <= pix0_d;
      pix1_q   <= pix1_d;
      fe_out_q <= fe_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.pixel_first   = pix0_q;
  assign out_o.pixel_second  = pix1_q;
  assign out_o.frame_end_out = fe_out_q;

  // input may only back off when both stages are full and the output stalls
  `Y2R_ASSERT_NOW(a_ready_only_when_full, !in_i.ready, s1_valid_q && out_valid_q && !out_o.ready, "input stalled while pipeline has room")

  // a stalled output beat must not be overwritten by stage one
  `Y2R_ASSERT_NEXT(a_out_hold, out_valid_q && !out_o.ready, out_valid_q && $stable(pix0_q) && $stable(pix1_q) && $stable(fe_out_q), "output beat changed under stall")

  // a full stage one that advances always reaches the output
  `Y2R_ASSERT_NEXT(a_s1_forward, s1_valid_q && advance, out_valid_q, "stage one beat lost")

endmodule

// ===== hdl/y2r_chroma.sv =====
// Chroma unit: turns the shared U/V pair into per-channel offsets.
// Depends on y2r_pkg.
module y2r_chroma (
  input  logic             [7:0] chroma_blue_i,
  input  logic             [7:0] chroma_red_i,
  output y2r_pkg::chroma_t       terms_o
);
  import y2r_pkg::*;

  logic signed [7:0]  u_s, v_s;
  logic signed [16:0] prod_rv, prod_gu, prod_gv, prod_bu;

  assign u_s = signed'(chroma_blue_i ^ ChromaBias);
  assign v_s = signed'(chroma_red_i ^ ChromaBias);

  assign prod_rv = 17'(v_s * CoefRV);
  assign prod_gu = 17'(u_s * CoefGU);
  assign prod_gv = 17'(v_s * CoefGV);
  assign prod_bu = 17'(u_s * CoefBU);

  // [16:8] of a signed product is its floor shift by 8
  always_comb begin
    terms_o.r_off = {v_s[7], v_s} + prod_rv[16:8];
    terms_o.g_off = 9'sd0 - prod_gu[16:8] - prod_gv[16:8];
    terms_o.b_off = {u_s[7], u_s} + prod_bu[16:8];
  end

endmodule

// ===== hdl/y2r_lane.sv =====
// Pixel lane: adds luma to the chroma offsets, clamps and packs one pixel.
// Depends on y2r_pkg.
module y2r_lane (
  input  logic             [7:0]  luma_i,
  input  y2r_pkg::chroma_t        terms_i,
  output logic             [15:0] pixel_o
);
  import y2r_pkg::*;

  logic signed [9:0] r_sum, g_sum, b_sum;

  assign r_sum = signed'({2'b00, luma_i}) + {terms_i.r_off[8], terms_i.r_off};
  assign g_sum = signed'({2'b00, luma_i}) + {terms_i.g_off[8], terms_i.g_off};
  assign b_sum = signed'({2'b00, luma_i}) + {terms_i.b_off[8], terms_i.b_off};

  assign pixel_o = pack565_swapped(clamp_u8(r_sum), clamp_u8(g_sum), clamp_u8(b_sum));

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the YUYV to RGB565 converter.
// Depends on y2r_in_if, y2r_out_if and yuyv_to_rgb565_converter.
// Predicts each RGB565 pair per macropixel and checks beats in order.
`timescale 1ns / 100ps

module tb;

  // BT.601-style coefficients in 1/256 units and the chroma offset
  localparam int RedFromCr   = 103;
  localparam int GreenFromCb = 88;
  localparam int GreenFromCr = 183;
  localparam int BlueFromCb  = 198;
  localparam int ChromaZero  = 128;
  localparam int ChannelMax  = 255;

  localparam int DrainLimit   = 20000;  // cycles to wait for the pipe to empty
  localparam int PipeLatency  = 4;      // two register stages, with margin
  localparam int HoldOffLen   = 300;    // long sink stall for the fill test
  localparam int PhaseBeats   = 470;

  typedef struct packed {
    logic [7:0] luma_first;
    logic [7:0] chroma_blue;
    logic [7:0] luma_second;
    logic [7:0] chroma_red;
    logic       frame_end;
  } yuyv_beat_t;

  typedef struct packed {
    logic [15:0] pixel_first;
    logic [15:0] pixel_second;
    logic        frame_end_out;
  } rgb_pair_t;

  logic clk = 1'b0;
  logic rst_n;

  y2r_in_if  in_ch ();
  y2r_out_if out_ch ();

  yuyv_to_rgb565_converter uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // Free-running clock, 4 ns period
  always #2 clk = ~clk;

  // Pairs predicted at input acceptance, waiting for their output beat
  rgb_pair_t pending_pairs[$];
  rgb_pair_t expected_pair;

  int src_idle_pct     = 0;
  int sink_stall_pct   = 0;
  int hold_off_cycles  = 0;
  int frame_beats_left = 0;

  int error_count  = 0;
  int beats_in     = 0;
  int pairs_out    = 0;
  int frames_out   = 0;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Clamp one color channel into 0..255
  function automatic logic [7:0] saturate_channel(input int level);
    if (level > ChannelMax) return 8'hff;
    if (level < 0) return 8'h00;
    return level[7:0];
  endfunction

  // One pixel from luma and the signed chroma offsets. Products are floored
  // by the arithmetic shift, so negative offsets round toward minus infinity.
  function automatic logic [15:0] rgb565_swapped(input int luma, input int cb,
                                                 input int cr);
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] word;
    red   = saturate_channel(luma + cr + ((cr * RedFromCr) >>> 8));
    green = saturate_channel(luma - ((cb * GreenFromCb) >>> 8)
                                  - ((cr * GreenFromCr) >>> 8));
    blue  = saturate_channel(luma + cb + ((cb * BlueFromCb) >>> 8));
    word  = (16'(red & 8'hf8) << 8) | (16'(green & 8'hfc) << 3)
          | (16'(blue & 8'hf8) >> 3);
    // high byte goes first in memory, so it lands in the low half
    return {word[7:0], word[15:8]};
  endfunction

  function automatic rgb_pair_t predict_rgb_pair(input yuyv_beat_t mp);
    int cb;
    int cr;
    rgb_pair_t pair;
    cb = int'(mp.chroma_blue) - ChromaZero;
    cr = int'(mp.chroma_red) - ChromaZero;
    pair.pixel_first   = rgb565_swapped(int'(mp.luma_first), cb, cr);
    pair.pixel_second  = rgb565_swapped(int'(mp.luma_second), cb, cr);
    pair.frame_end_out = mp.frame_end;
    return pair;
  endfunction

  // ---------------------------------------------------------------------------
  // Sink: drive ready. A requested hold-off is counted down here; otherwise
  // stall at the current rate.
  // ---------------------------------------------------------------------------
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_off_cycles--;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Scoreboard: predict on every accepted input beat, then match every
  // accepted output beat against the oldest prediction. All values sampled
  // here are the ones settled before the edge.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string field, input logic [15:0] exp_val,
                                 input logic [15:0] act_val);
    $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field,
             exp_val, act_val);
    error_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        pending_pairs.push_back(predict_rgb_pair({in_ch.luma_first,
          in_ch.chroma_blue, in_ch.luma_second, in_ch.chroma_red,
          in_ch.frame_end}));
        beats_in++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_pairs.size() == 0) begin
          $display("%0t ns: output beat with nothing expected, actual %h %h %b",
                   $time, out_ch.pixel_first, out_ch.pixel_second,
                   out_ch.frame_end_out);
          error_count++;
        end else begin
          expected_pair = pending_pairs.pop_front();
          if (out_ch.pixel_first !== expected_pair.pixel_first)
            report_mismatch("pixel_first", expected_pair.pixel_first,
                            out_ch.pixel_first);
          if (out_ch.pixel_second !== expected_pair.pixel_second)
            report_mismatch("pixel_second", expected_pair.pixel_second,
                            out_ch.pixel_second);
          if (out_ch.frame_end_out !== expected_pair.frame_end_out)
            report_mismatch("frame_end_out", 16'(expected_pair.frame_end_out),
                            16'(out_ch.frame_end_out));
          pairs_out++;
          if (expected_pair.frame_end_out) frames_out++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Source side
  // ---------------------------------------------------------------------------

  // Offer one macropixel and hold it until the block takes it. While idle,
  // drop valid and scramble the payload so stale data is never trusted.
  task automatic send_macropixel(input yuyv_beat_t mp);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid       <= 1'b0;
      in_ch.luma_first  <= 8'($urandom);
      in_ch.chroma_blue <= 8'($urandom);
      in_ch.luma_second <= 8'($urandom);
      in_ch.chroma_red  <= 8'($urandom);
      in_ch.frame_end   <= 1'($urandom);
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.luma_first  <= mp.luma_first;
    in_ch.chroma_blue <= mp.chroma_blue;
    in_ch.luma_second <= mp.luma_second;
    in_ch.chroma_red  <= mp.chroma_red;
    in_ch.frame_end   <= mp.frame_end;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Drop valid and wait for every predicted pair to come out
  task automatic wait_drained();
    int waited;
    waited = 0;
    in_ch.valid <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (pending_pairs.size() != 0 && waited < DrainLimit);
  endtask

  // Sample byte weighted toward the saturation and zero-chroma corners
  function automatic logic [7:0] skewed_sample();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hff;
      2: return 8'($urandom_range(126, 130));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Random macropixel inside a frame of random length; frame_end marks the
  // last beat, with an occasional stray mark thrown in.
  function automatic yuyv_beat_t next_random_macropixel();
    yuyv_beat_t mp;
    if (frame_beats_left == 0) frame_beats_left = $urandom_range(1, 48);
    frame_beats_left--;
    mp.luma_first  = skewed_sample();
    mp.chroma_blue = skewed_sample();
    mp.luma_second = skewed_sample();
    mp.chroma_red  = skewed_sample();
    mp.frame_end   = (frame_beats_left == 0) || ($urandom_range(0, 49) == 0);
    return mp;
  endfunction

  task automatic run_random_phase(input int src_pct, input int sink_pct,
                                  input int beats);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    for (int i = 0; i < beats; i++) begin
      // leave some stretches at full rate even in the idling phases
      if ((i / 64) % 4 == 3) begin
        src_idle_pct   = 0;
        sink_stall_pct = 0;
      end else begin
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
      end
      send_macropixel(next_random_macropixel());
    end
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Corners: zero and full-scale fields, neutral chroma, every channel
  // clamped high and low, chroma just below and above zero (floor of small
  // negative products), alternating bit patterns, frame_end both ways.
  task automatic test_directed_corners();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    send_macropixel(yuyv_beat_t'{8'h00, 8'h00, 8'h00, 8'h00, 1'b0});
    send_macropixel(yuyv_beat_t'{8'hff, 8'hff, 8'hff, 8'hff, 1'b1});
    send_macropixel(yuyv_beat_t'{8'h00, 8'h80, 8'hff, 8'h80, 1'b0});
    send_macropixel(yuyv_beat_t'{8'hff, 8'h80, 8'h00, 8'h80, 1'b0});
    send_macropixel(yuyv_beat_t'{8'h00, 8'h00, 8'hff, 8'h00, 1'b0});
    send_macropixel(yuyv_beat_t'{8'h00, 8'hff, 8'hff, 8'hff, 1'b1});
    send_macropixel(yuyv_beat_t'{8'h80, 8'h00, 8'h80, 8'hff, 1'b0});
    send_macropixel(yuyv_beat_t'{8'h80, 8'hff, 8'h80, 8'h00, 1'b0});
    send_macropixel(yuyv_beat_t'{8'h10, 8'h7f, 8'heb, 8'h7f, 1'b0});
    send_macropixel(yuyv_beat_t'{8'heb, 8'h81, 8'h10, 8'h81, 1'b1});
    send_macropixel(yuyv_beat_t'{8'h55, 8'haa, 8'h55, 8'haa, 1'b1});
    send_macropixel(yuyv_beat_t'{8'haa, 8'h55, 8'haa, 8'h55, 1'b0});
    send_macropixel(yuyv_beat_t'{8'hff, 8'hff, 8'hf0, 8'h80, 1'b0});
    send_macropixel(yuyv_beat_t'{8'h00, 8'h80, 8'h08, 8'h00, 1'b0});
    send_macropixel(yuyv_beat_t'{8'h00, 8'h00, 8'h04, 8'h80, 1'b0});
    send_macropixel(yuyv_beat_t'{8'hff, 8'h00, 8'hfe, 8'h00, 1'b0});
    send_macropixel(yuyv_beat_t'{8'h01, 8'h7f, 8'h01, 8'h81, 1'b0});
    send_macropixel(yuyv_beat_t'{8'h7f, 8'h80, 8'h80, 8'h7f, 1'b1});
    send_macropixel(yuyv_beat_t'{8'h40, 8'h01, 8'hc0, 8'hfe, 1'b0});
    send_macropixel(yuyv_beat_t'{8'hc0, 8'hfe, 8'h40, 8'h01, 1'b1});
    wait_drained();
  endtask

  task automatic test_full_rate();
    run_random_phase(0, 0, PhaseBeats);
  endtask

  task automatic test_sparse_source();
    run_random_phase(86, 0, PhaseBeats);
  endtask

  task automatic test_slow_sink();
    run_random_phase(0, 86, PhaseBeats);
  endtask

  task automatic test_mixed_idling();
    run_random_phase(26, 26, PhaseBeats);
  endtask

  // Hold the sink off for a long stretch while the source keeps offering
  // beats: the pipe fills, in_i.ready must fall, and nothing may be lost.
  task automatic test_sink_hold_off();
    src_idle_pct    = 0;
    sink_stall_pct  = 0;
    hold_off_cycles = HoldOffLen;
    for (int i = 0; i < 48; i++) send_macropixel(next_random_macropixel());
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.luma_first  = 8'h00;
    in_ch.chroma_blue = 8'h00;
    in_ch.luma_second = 8'h00;
    in_ch.chroma_red  = 8'h00;
    in_ch.frame_end   = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_corners();
    test_sink_hold_off();
    test_full_rate();
    test_sparse_source();
    test_slow_sink();
    test_mixed_idling();

    wait_drained();
    repeat (PipeLatency) @(posedge clk);
    if (pending_pairs.size() != 0) begin
      $display("%0t ns: %0d expected pixel pairs never came out", $time,
               pending_pairs.size());
      error_count++;
    end

    $display("Converted %0d YUYV beats into %0d RGB565 pairs, %0d frame ends seen",
             beats_in, pairs_out, frames_out);
    $display("Covered corners, full rate, sparse source, slow sink, mixed idling "
             , "and a %0d-cycle sink hold-off; %0d errors", HoldOffLen, error_count);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2000000;
    $display("%0t ns: watchdog expired with %0d pairs pending", $time,
             pending_pairs.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/y2r_pkg.sv
hdl/y2r_in_if.sv
hdl/y2r_out_if.sv
hdl/y2r_chroma.sv
hdl/y2r_lane.sv
hdl/yuyv_to_rgb565_converter.sv
tb/sv/tb.sv
